// ===== design/mvt_pkg.sv =====
package mvt_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic vote_en;
    logic tally_en;
    logic clear;
  } vote_ctl_t;

  typedef struct packed {
    logic first_ok;
    logic second_ok;
  } vote_sts_t;

endpackage

// ===== design/mvt_ram.sv =====
module mvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/mvt_vote.sv =====
module mvt_vote #(
  parameter int VALUE_BITS = 32,
  parameter int LEN_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mvt_pkg::vote_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0] vote_value,
  input  logic [VALUE_BITS-1:0] tally_value,
  input  logic [LEN_BITS-1:0]   list_len,
  output logic [VALUE_BITS-1:0] cand_first,
  output logic [VALUE_BITS-1:0] cand_second,
  output mvt_pkg::vote_sts_t    sts
);

  logic [VALUE_BITS-1:0] c1_r, c1_nxt, c2_r, c2_nxt;
  logic [LEN_BITS-1:0]   v1_r, v1_nxt, v2_r, v2_nxt;
  logic [LEN_BITS-1:0]   t1_r, t1_nxt, t2_r, t2_nxt;
  logic                  s1_r, s1_nxt, s2_r, s2_nxt;
  logic                  m1, m2;
  logic [LEN_BITS+1:0]   t1_x3, t2_x3, len_ext;

  assign m1 = s1_r && (vote_value == c1_r);
  assign m2 = s2_r && (vote_value == c2_r);

  always_comb begin
    c1_nxt = c1_r;
    c2_nxt = c2_r;
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    if (ctl.clear) begin
      c1_nxt = '0;
      c2_nxt = '0;
      v1_nxt = '0;
      v2_nxt = '0;
      s1_nxt = 1'b0;
      s2_nxt = 1'b0;
      t1_nxt = '0;
      t2_nxt = '0;
    end else if (ctl.vote_en) begin
      priority if (v1_r == '0 && !m2) begin
        c1_nxt = vote_value;
        s1_nxt = 1'b1;
        v1_nxt = LEN_BITS'(1);
      end else if (v2_r == '0 && !m1) begin
        c2_nxt = vote_value;
        s2_nxt = 1'b1;
        v2_nxt = LEN_BITS'(1);
      end else if (m1) begin
        v1_nxt = v1_r + LEN_BITS'(1);
      end else if (m2) begin
        v2_nxt = v2_r + LEN_BITS'(1);
      end else begin
        v1_nxt = v1_r - LEN_BITS'(1);
        v2_nxt = v2_r - LEN_BITS'(1);
      end
    end else if (ctl.tally_en) begin
      priority if (s1_r && tally_value == c1_r) begin
        t1_nxt = t1_r + LEN_BITS'(1);
      end else if (s2_r && tally_value == c2_r) begin
        t2_nxt = t2_r + LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      v1_r <= '0;
      v2_r <= '0;
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      t1_r <= '0;
      t2_r <= '0;
    end else begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
    end
  end

  // A tally exceeds floor(n/3) exactly when three times the tally exceeds n.
  assign t1_x3   = {1'b0, t1_r, 1'b0} + {2'b00, t1_r};
  assign t2_x3   = {1'b0, t2_r, 1'b0} + {2'b00, t2_r};
  assign len_ext = {2'b00, list_len};

  assign sts.first_ok  = s1_r && (t1_x3 > len_ext);
  assign sts.second_ok = s2_r && (t2_x3 > len_ext) && !(s1_r && c1_r == c2_r);

  assign cand_first  = c1_r;
  assign cand_second = c2_r;

endmodule

// ===== design/majority_vote_third_unit.sv =====
// Requests are accepted whenever the unit is loading; a request without the last flag gives no result.
// After the last request, the re-count reads the list memory once per stored element,
// one read per cycle; then one or two results follow.
// Reset (rst_n low, synchronous) clears all list state; the memory is not cleared.
module majority_vote_third_unit #(
  parameter int MAX_ITEMS = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_element,
  output logic                         out_found,
  output logic                         out_done_res
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int LW = $clog2(MAX_ITEMS + 1);

  mvt_pkg::state_t    state_r, state_nxt;
  mvt_pkg::vote_ctl_t vctl;
  mvt_pkg::vote_sts_t vsts;

  logic [LW-1:0]         len_r, len_nxt;
  logic [LW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  emit_second_r, emit_second_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_element_r, out_element_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  in_acc, store_ok, rd_issue, out_load, finish;
  logic [VALUE_BITS-1:0] rd_data, cand_first, cand_second;

  assign in_ready = (state_r == mvt_pkg::ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign store_ok = in_acc && (len_r < LW'(MAX_ITEMS));
  assign rd_issue = (state_r == mvt_pkg::ST_COUNT) && (rd_ptr_r < len_r);
  assign out_load = !out_valid_r || out_ready;

  mvt_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_ok),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (rd_issue),
    .rd_addr (rd_ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  mvt_vote #(
    .VALUE_BITS(VALUE_BITS),
    .LEN_BITS  (LW)
  ) u_vote (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (vctl),
    .vote_value  (in_value),
    .tally_value (rd_data),
    .list_len    (len_r),
    .cand_first  (cand_first),
    .cand_second (cand_second),
    .sts         (vsts)
  );

  always_comb begin
    finish = 1'b0;
    if (state_r == mvt_pkg::ST_EMIT && out_load) begin
      finish = emit_second_r || !(vsts.first_ok && vsts.second_ok);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvt_pkg::ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = mvt_pkg::ST_COUNT;
        end
      end
      mvt_pkg::ST_COUNT: begin
        if (!rd_issue && !rd_pend_r) begin
          state_nxt = mvt_pkg::ST_EMIT;
        end
      end
      mvt_pkg::ST_EMIT: begin
        if (finish) begin
          state_nxt = mvt_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mvt_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    len_nxt         = len_r;
    rd_ptr_nxt      = rd_ptr_r;
    rd_pend_nxt     = rd_issue;
    emit_second_nxt = emit_second_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_element_nxt = out_element_r;
    out_found_nxt   = out_found_r;
    out_done_nxt    = out_done_r;
    vctl.vote_en    = store_ok;
    vctl.tally_en   = rd_pend_r;
    vctl.clear      = finish;
    unique case (state_r)
      mvt_pkg::ST_LOAD: begin
        rd_ptr_nxt = '0;
        if (store_ok) begin
          len_nxt = len_r + LW'(1);
        end
      end
      mvt_pkg::ST_COUNT: begin
        if (rd_issue) begin
          rd_ptr_nxt = rd_ptr_r + LW'(1);
        end
      end
      mvt_pkg::ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (emit_second_r) begin
            out_element_nxt = cand_second;
            out_found_nxt   = 1'b1;
            out_done_nxt    = 1'b1;
          end else if (vsts.first_ok) begin
            out_element_nxt = cand_first;
            out_found_nxt   = 1'b1;
            out_done_nxt    = !vsts.second_ok;
            emit_second_nxt = vsts.second_ok;
          end else if (vsts.second_ok) begin
            out_element_nxt = cand_second;
            out_found_nxt   = 1'b1;
            out_done_nxt    = 1'b1;
          end else begin
            out_element_nxt = '0;
            out_found_nxt   = 1'b0;
            out_done_nxt    = 1'b1;
          end
          if (finish) begin
            len_nxt         = '0;
            emit_second_nxt = 1'b0;
          end
        end
      end
      default: begin
        len_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mvt_pkg::ST_LOAD;
      len_r         <= '0;
      rd_ptr_r      <= '0;
      rd_pend_r     <= 1'b0;
      emit_second_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      len_r         <= len_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      rd_pend_r     <= rd_pend_nxt;
      emit_second_r <= emit_second_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_element_r <= out_element_nxt;
    out_found_r   <= out_found_nxt;
    out_done_r    <= out_done_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_element  = out_element_r;
  assign out_found    = out_found_r;
  assign out_done_res = out_done_r;

`ifndef NO_ASSERTIONS
  a_pend_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == mvt_pkg::ST_COUNT)
    else $error("memory read pending outside the re-count");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_ITEMS))
    else $error("list length beyond capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_done_r)
    else $error("empty marker without done flag");

  a_second_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_second_r |-> state_r == mvt_pkg::ST_EMIT)
    else $error("second result pending outside emit");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> state_r == mvt_pkg::ST_LOAD && len_r == '0 && out_valid_r && out_done_r)
    else $error("list end did not clear state");
`endif

endmodule

// ===== verif/majority_vote_third_checker.sv =====
module majority_vote_third_checker #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [VALUE_BITS-1:0] out_element,
  input  logic                         out_found,
  input  logic                         out_done_res,
  output int                           error_count,
  output int                           answers_waiting,
  output int                           results_checked,
  output int                           answers_found
);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t element;
    logic   found;
    logic   done_res;
  } answer_t;

  value_t  list_mem [MAX_ITEMS];
  int      list_len;
  value_t  cand_a;
  value_t  cand_b;
  int      votes_a;
  int      votes_b;
  logic    held_a;
  logic    held_b;
  answer_t expected_answers [$];

  function automatic void clear_vote();
    list_len = 0;
    cand_a   = '0;
    cand_b   = '0;
    votes_a  = 0;
    votes_b  = 0;
    held_a   = 1'b0;
    held_b   = 1'b0;
  endfunction

  function automatic void queue_answer(value_t element, logic found, logic done_res);
    answer_t ans;
    ans.element  = element;
    ans.found    = found;
    ans.done_res = done_res;
    expected_answers = {expected_answers, ans};
  endfunction

  function automatic void take_element(value_t v);
    logic hit_a;
    logic hit_b;
    hit_a = held_a && (v == cand_a);
    hit_b = held_b && (v == cand_b);
    list_mem[list_len] = v;
    list_len++;
    if (votes_a == 0 && !hit_b) begin
      cand_a  = v;
      held_a  = 1'b1;
      votes_a = 1;
    end else if (votes_b == 0 && !hit_a) begin
      cand_b  = v;
      held_b  = 1'b1;
      votes_b = 1;
    end else if (hit_a) begin
      votes_a++;
    end else if (hit_b) begin
      votes_b++;
    end else begin
      votes_a--;
      votes_b--;
    end
  endfunction

  // Re-counts both candidates over the stored list and queues the answers.
  function automatic void close_list();
    int   tally_a;
    int   tally_b;
    int   third;
    logic report_a;
    logic report_b;
    tally_a = 0;
    tally_b = 0;
    for (int i = 0; i < list_len; i++) begin
      if (held_a && list_mem[i] == cand_a) begin
        tally_a++;
      end else if (held_b && list_mem[i] == cand_b) begin
        tally_b++;
      end
    end
    third    = list_len / 3;
    report_a = held_a && (tally_a > third);
    report_b = held_b && (tally_b > third) && !(held_a && cand_a == cand_b);
    if (report_a) begin
      queue_answer(cand_a, 1'b1, !report_b);
    end
    if (report_b) begin
      queue_answer(cand_b, 1'b1, 1'b1);
    end
    if (!report_a && !report_b) begin
      queue_answer('0, 1'b0, 1'b1);
    end
    clear_vote();
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      clear_vote();
      expected_answers.delete();
      error_count     <= 0;
      results_checked <= 0;
      answers_found   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (list_len < MAX_ITEMS) begin
          take_element(in_value);
        end
        if (in_last) begin
          close_list();
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_element, out_found, out_done_res};
        results_checked <= results_checked + 1;
        if (got.found === 1'b1) begin
          answers_found <= answers_found + 1;
        end
        if (expected_answers.size() == 0) begin
          error_count <= error_count + 1;
          $display("%0t: expected no result, got element=%0d found=%0b done_res=%0b",
                   $time, got.element, got.found, got.done_res);
        end else begin
          want = expected_answers.pop_front();
          if (got.element !== want.element || got.found !== want.found ||
              got.done_res !== want.done_res) begin
            error_count <= error_count + 1;
            $display("%0t: expected element=%0d found=%0b done_res=%0b,",
                     $time, want.element, want.found, want.done_res);
            $display("%0t: got element=%0d found=%0b done_res=%0b",
                     $time, got.element, got.found, got.done_res);
          end
        end
      end
    end
    answers_waiting <= expected_answers.size();
  end

endmodule

// ===== verif/tb_majority_vote_third_unit.sv =====
module tb_majority_vote_third_unit;

  // The store is kept small so that lists running past its capacity stay cheap to reach.
  localparam int LIST_CAP     = 64;
  localparam int WIDTH        = 32;
  localparam int ITEM_BUDGET  = 1050;
  localparam int DRAIN_CYCLES = 2 * LIST_CAP + 16;
  localparam int CYCLE_LIMIT  = 300000;

  typedef logic signed [WIDTH-1:0] value_t;

  localparam value_t VAL_MIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(WIDTH-1){1'b1}}};

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  value_t in_value  = '0;
  logic   in_last   = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  value_t out_element;
  logic   out_found;
  logic   out_done_res;

  int error_count;
  int answers_waiting;
  int results_checked;
  int answers_found;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;
  int lists_sent  = 0;

  always #5 clk = ~clk;

  majority_vote_third_unit #(
    .MAX_ITEMS (LIST_CAP),
    .VALUE_BITS(WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_element (out_element),
    .out_found   (out_found),
    .out_done_res(out_done_res)
  );

  majority_vote_third_checker #(
    .MAX_ITEMS (LIST_CAP),
    .VALUE_BITS(WIDTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_element    (out_element),
    .out_found      (out_found),
    .out_done_res   (out_done_res),
    .error_count    (error_count),
    .answers_waiting(answers_waiting),
    .results_checked(results_checked),
    .answers_found  (answers_found)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input value_t v, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (last) begin
      lists_sent++;
    end
  endtask

  // Most lists draw from a few values so that majorities are common.
  task automatic send_random_list(inout int stored, inout int long_lists);
    value_t pool [4];
    int     pool_size;
    int     len;
    int     mode;
    logic   noise;
    value_t v;
    pool_size = $urandom_range(4, 1);
    for (int i = 0; i < 4; i++) begin
      pool[i] = pick_value();
    end
    mode = $urandom_range(99);
    if (mode < 75) begin
      len = $urandom_range(10, 1);
    end else if (mode < 92) begin
      len = $urandom_range(LIST_CAP, 11);
    end else begin
      len = $urandom_range(LIST_CAP + 6, LIST_CAP + 1);
      long_lists++;
    end
    noise = ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      if (noise || $urandom_range(99) < 12) begin
        v = pick_value();
      end else begin
        v = pool[$urandom_range($urandom_range(pool_size - 1, 0), 0)];
      end
      send_item(v, i == len - 1);
    end
    stored += (len < LIST_CAP) ? len : LIST_CAP;
  endtask

  initial begin
    int stored;
    int long_lists;
    stored     = 0;
    long_lists = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    send_item(0, 1'b0);
    send_item(0, 1'b1);
    send_item(VAL_MIN, 1'b0);
    send_item(-1, 1'b1);
    send_item(-1, 1'b0);
    send_item(5, 1'b0);
    send_item(-1, 1'b1);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b1);
    send_item(7, 1'b0);
    send_item(8, 1'b0);
    send_item(7, 1'b0);
    send_item(8, 1'b1);
    send_item(4, 1'b0);
    send_item(9, 1'b0);
    send_item(9, 1'b0);
    send_item(9, 1'b1);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      while (stored < (phase + 1) * ITEM_BUDGET / 4) begin
        send_random_list(stored, long_lists);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d lists; %0d random elements stored, %0d lists overran the %0d-entry store.",
             lists_sent, stored, long_lists, LIST_CAP);
    $display("Checked %0d results, %0d of them majority values, with %0d mismatches.",
             results_checked, answers_found, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
